// ===== rtl/core/sqc_pkg.sv =====
package sqc_pkg;

	localparam int MAX_COLS_DEF = 64;
	localparam int MAX_ROWS_DEF = 64;

	localparam int CFG_W     = 7;
	localparam int IDX_W     = 2;
	localparam int POS_OUT_W = 7;
	localparam int COUNT_W   = 12;
	// wide enough for any size limit up to 1024
	localparam int CMP_W     = 11;

	localparam logic [IDX_W-1:0] REG_IMAGE_ROWS = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_IMAGE_COLS = IDX_W'(1);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic KIND_ANCHOR  = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// position flags of one pixel, worked out when it is taken in
	typedef struct packed {
		logic                 first;
		logic                 row_ge1;
		logic                 row_ge2;
		logic                 col_ge1;
		logic                 end_col;
		logic                 last_row;
		logic [POS_OUT_W-1:0] row_out;
		logic [POS_OUT_W-1:0] col_out;
	} item_info_t;

	// records produced by one pixel
	typedef struct packed {
		logic                 anchor_v;
		logic                 verdict_v;
		logic [POS_OUT_W-1:0] row;
		logic [POS_OUT_W-1:0] col;
		logic [COUNT_W-1:0]   count;
		logic                 ok;
	} result_t;

	// clamped size minus one
	function automatic logic [CMP_W-1:0] size_last(input logic [CFG_W-1:0] v,
			input logic [CMP_W-1:0] hi);
		logic [CMP_W-1:0] w;
		w = CMP_W'(v);
		if (w < CMP_W'(2)) begin
			w = CMP_W'(2);
		end else if (w > hi) begin
			w = hi;
		end
		return w - CMP_W'(1);
	endfunction

endpackage

// ===== rtl/core/square_cover_check_core.sv =====
// A pixel transaction is registered in the read stage, then its records in the output register.
// Throughput: one pixel per clock while the output has room, held by one read and one write per
// pixel on each line buffer; a frame's last pixel completing an anchor gives two records.
// Reset: control and counters clear, both size registers return to 2; the line buffers keep
// their contents, which the first two rows of each frame never use.
module square_cover_check_core import sqc_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  logic                 pixel,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 record_kind,
	output logic [POS_OUT_W-1:0] anchor_row,
	output logic [POS_OUT_W-1:0] anchor_col,
	output logic [COUNT_W-1:0]   anchor_count,
	output logic                 image_ok,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);

	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	logic [RW-1:0]    r_q;
	logic [CW-1:0]    c_q;

	logic             valid_s1;
	item_info_t       info_s1;
	logic             pixel_s1;
	logic [CW-1:0]    anc_addr_s1;

	logic [CMP_W-1:0] rows_last;
	logic [CMP_W-1:0] cols_last;
	logic             end_col;
	logic             last_row;
	logic             accept;
	logic             adv;
	logic             out_free;
	logic             cfg_wr;
	item_info_t       info_in;

	logic             rd_pix;
	logic             rd_anc;
	logic             anc_we;
	logic             anc_bit;
	result_t          res;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	assign rows_last = size_last(rows_q, CMP_W'(MAX_ROWS));
	assign cols_last = size_last(cols_q, CMP_W'(MAX_COLS));
	assign end_col   = CMP_W'(c_q) == cols_last;
	assign last_row  = CMP_W'(r_q) == rows_last;

	assign adv         = valid_s1 & out_free;
	assign pixel_stall = valid_s1 & ~out_free;
	assign accept      = pixel_valid & ~pixel_stall;

	always_comb begin
		info_in.first    = (r_q == '0) && (c_q == '0);
		info_in.row_ge1  = r_q != '0;
		info_in.row_ge2  = r_q > RW'(1);
		info_in.col_ge1  = c_q != '0;
		info_in.end_col  = end_col;
		info_in.last_row = last_row;
		info_in.row_out  = POS_OUT_W'(r_q);
		info_in.col_out  = POS_OUT_W'(c_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= CFG_W'(2);
			cols_q   <= CFG_W'(2);
			r_q      <= '0;
			c_q      <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr && (cfg_index == REG_IMAGE_ROWS || cfg_index == REG_IMAGE_COLS)) begin
				if (cfg_index == REG_IMAGE_ROWS) begin
					rows_q <= cfg_data;
				end else begin
					cols_q <= cfg_data;
				end
				r_q <= '0;
				c_q <= '0;
			end else if (accept) begin
				if (end_col) begin
					c_q <= '0;
					r_q <= last_row ? '0 : r_q + RW'(1);
				end else begin
					c_q <= c_q + CW'(1);
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1     <= info_in;
			pixel_s1    <= pixel;
			anc_addr_s1 <= c_q - CW'(1);
		end
	end

	// row above: pixel of each column
	sqc_ram #(
		.WIDTH (1),
		.DEPTH (MAX_COLS)
	) u_pix_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (c_q),
		.wdata (pixel),
		.re    (accept),
		.raddr (c_q),
		.rdata (rd_pix)
	);

	// anchors whose top row is two rows up, by left column
	sqc_ram #(
		.WIDTH (1),
		.DEPTH (MAX_COLS)
	) u_anc_ram (
		.clk   (clk),
		.we    (anc_we),
		.waddr (anc_addr_s1),
		.wdata (anc_bit),
		.re    (accept),
		.raddr (c_q - CW'(1)),
		.rdata (rd_anc)
	);

	sqc_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.info    (info_s1),
		.pixel   (pixel_s1),
		.rd_pix  (rd_pix),
		.rd_anc  (rd_anc),
		.res     (res),
		.anc_we  (anc_we),
		.anc_bit (anc_bit)
	);

	sqc_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv),
		.res          (res),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.free         (out_free),
		.record_kind  (record_kind),
		.anchor_row   (anchor_row),
		.anchor_col   (anchor_col),
		.anchor_count (anchor_count),
		.image_ok     (image_ok),
		.last         (last)
	);

	// anchor write-back never lands on the entry being read for the next pixel
	a_anc_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(anc_we && accept) |-> (anc_addr_s1 != c_q - CW'(1)))
		else $error("anchor buffer write and read hit the same entry");

	// input is held back only by records still waiting at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> result_valid)
		else $error("pixel stalled with nothing pending at the output");

	// a record only shows up after a pixel left the read stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s1))
		else $error("record appeared without a pixel in the read stage");

endmodule

// ===== rtl/core/sqc_ram.sv =====
module sqc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/sqc_eval.sv =====
module sqc_eval import sqc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  item_info_t info,
	input  logic       pixel,
	input  logic       rd_pix,
	input  logic       rd_anc,
	output result_t    res,
	output logic       anc_we,
	output logic       anc_bit
);

	logic               pix_m1_q;
	logic               pa_m1_q;
	logic               ca_m1_q;
	logic               left_q;
	logic [COUNT_W-1:0] count_q;
	logic               unc_q;

	logic               act;
	logic               pa1;
	logic               a;
	logic               unc_hit;
	logic [COUNT_W-1:0] cnt_base;
	logic [COUNT_W-1:0] cnt_new;
	logic               unc_new;

	always_comb begin
		act = info.row_ge1 & info.col_ge1;
		// anchors of the row above are blank while on row one
		pa1 = info.row_ge2 & info.col_ge1 & rd_anc;
		a   = act & pix_m1_q & rd_pix & left_q & pixel;

		// pixel above-left, pixel above in last column, then the last row itself
		unc_hit = act & (
			(pix_m1_q & ~(pa_m1_q | pa1 | ca_m1_q | a)) |
			(info.end_col & rd_pix & ~(pa1 | a)) |
			(info.last_row & ((left_q & ~(ca_m1_q | a)) |
				(info.end_col & pixel & ~a))));

		cnt_base = info.first ? '0 : count_q;
		cnt_new  = (a && cnt_base != COUNT_MAX) ? cnt_base + COUNT_W'(1) : cnt_base;
		unc_new  = (info.first ? 1'b0 : unc_q) | unc_hit;

		res.anchor_v  = a;
		res.verdict_v = info.end_col & info.last_row;
		res.row       = info.row_out;
		res.col       = info.col_out;
		res.count     = cnt_new;
		res.ok        = ~unc_new;

		anc_we  = adv & act;
		anc_bit = a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			unc_q   <= 1'b0;
		end else if (adv) begin
			count_q <= cnt_new;
			unc_q   <= unc_new;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_m1_q <= rd_pix;
			pa_m1_q  <= pa1;
			ca_m1_q  <= a;
			left_q   <= pixel;
		end
	end

endmodule

// ===== rtl/core/sqc_out.sv =====
module sqc_out import sqc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  result_t              res,
	input  logic                 result_stall,
	output logic                 result_valid,
	output logic                 free,
	output logic                 record_kind,
	output logic [POS_OUT_W-1:0] anchor_row,
	output logic [POS_OUT_W-1:0] anchor_col,
	output logic [COUNT_W-1:0]   anchor_count,
	output logic                 image_ok,
	output logic                 last
);

	logic                 anc_v_q;
	logic                 ver_v_q;
	logic [POS_OUT_W-1:0] row_q;
	logic [POS_OUT_W-1:0] col_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 ok_q;
	logic                 acc;

	assign result_valid = anc_v_q | ver_v_q;
	assign acc          = result_valid & ~result_stall;
	// room for new records once none wait or the last is taken
	assign free         = ~result_valid | (acc & ~(anc_v_q & ver_v_q));

	// anchor goes out ahead of the verdict
	assign record_kind  = anc_v_q ? KIND_ANCHOR : KIND_VERDICT;
	assign anchor_row   = anc_v_q ? row_q : '0;
	assign anchor_col   = anc_v_q ? col_q : '0;
	assign anchor_count = anc_v_q ? '0 : count_q;
	assign image_ok     = anc_v_q ? 1'b0 : ok_q;
	assign last         = ~anc_v_q & ver_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anc_v_q <= 1'b0;
			ver_v_q <= 1'b0;
		end else if (load) begin
			anc_v_q <= res.anchor_v;
			ver_v_q <= res.verdict_v;
		end else if (acc) begin
			if (anc_v_q) begin
				anc_v_q <= 1'b0;
			end else begin
				ver_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_q   <= res.row;
			col_q   <= res.col;
			count_q <= res.count;
			ok_q    <= res.ok;
		end
	end

endmodule

// ===== tb/square_cover_check_core_tb.sv =====
`timescale 1ns / 1ps

module square_cover_check_core_tb;
	import sqc_pkg::*;

	localparam int RANDOM_ITEMS  = 1900;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int NC            = MAX_COLS_DEF;
	localparam int NR            = MAX_ROWS_DEF;

	// indexes with no register behind them
	localparam logic [IDX_W-1:0] REG_SPARE_2 = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_SPARE_3 = IDX_W'(3);

	typedef enum int {STYLE_SQUARES, STYLE_FLAWED, STYLE_NOISE, STYLE_SOLID, STYLE_BLANK}
		frame_style_t;

	typedef struct {
		logic                 kind;
		logic [POS_OUT_W-1:0] row;
		logic [POS_OUT_W-1:0] col;
		logic [COUNT_W-1:0]   count;
		logic                 ok;
		logic                 last;
	} cover_rec_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 pixel_valid  = 1'b0;
	logic                 pixel        = 1'b0;
	logic                 result_stall = 1'b0;
	logic                 cfg_valid    = 1'b0;
	logic [IDX_W-1:0]     cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_data     = '0;
	logic                 pixel_stall;
	logic                 result_valid;
	logic                 record_kind;
	logic [POS_OUT_W-1:0] anchor_row;
	logic [POS_OUT_W-1:0] anchor_col;
	logic [COUNT_W-1:0]   anchor_count;
	logic                 image_ok;
	logic                 last;
	logic                 cfg_ready;

	square_cover_check_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.record_kind  (record_kind),
		.anchor_row   (anchor_row),
		.anchor_col   (anchor_col),
		.anchor_count (anchor_count),
		.image_ok     (image_ok),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// stimulus and expectations
	logic       pixel_backlog[$];
	cover_rec_t pending_records[$];
	logic       img [0:NR-1][0:NC-1];
	bit         tx_burst = 1'b0;
	bit         rx_burst = 1'b0;
	int         tx_gap, rx_hold, rx_draw;
	int         pixels_queued, pixels_taken, anchors_checked, verdicts_seen, clean_seen;
	int         cfg_writes, mismatches, cycle_count;
	cover_rec_t want;

	// opening checker state, mirrored
	logic [CFG_W-1:0]   rows_reg, cols_reg;
	int                 row_pos, col_pos;
	logic [NC-1:0]      above_px, anch_two_up, anch_one_up;
	logic               left_px;
	logic [COUNT_W-1:0] anchors_found;
	logic               uncovered;

	function automatic int eff_size(input logic [CFG_W-1:0] v, input int hi);
		if (v < 2)
			return 2;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic anchor_at(input logic [NC-1:0] a, input int idx);
		if (idx < 0 || idx >= NC)
			return 1'b0;
		return a[idx];
	endfunction

	// any anchor in columns idx-1..idx of either anchor row
	function automatic logic covered_by(input logic [NC-1:0] a, input logic [NC-1:0] b,
			input int idx);
		return anchor_at(a, idx - 1) | anchor_at(a, idx) | anchor_at(b, idx - 1) |
			anchor_at(b, idx);
	endfunction

	task automatic restart_frame();
		row_pos = 0;
		col_pos = 0;
		anchors_found = '0;
		uncovered = 1'b0;
	endtask

	task automatic apply_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		if (idx == REG_IMAGE_ROWS) begin
			rows_reg = val;
			restart_frame();
		end else if (idx == REG_IMAGE_COLS) begin
			cols_reg = val;
			restart_frame();
		end
	endtask

	task automatic predict_pixel(input logic p);
		int         nr, nc, ci;
		logic       endc, a;
		cover_rec_t rec;
		nr = eff_size(rows_reg, NR);
		nc = eff_size(cols_reg, NC);
		ci = col_pos;
		endc = (col_pos == nc - 1);
		if (col_pos == 0) begin
			if (row_pos == 0) begin
				anch_two_up = '0;
				anchors_found = '0;
				uncovered = 1'b0;
			end else begin
				anch_two_up = anch_one_up;
			end
			anch_one_up = '0;
		end
		if (row_pos >= 1 && col_pos >= 1) begin
			a = above_px[ci-1] & above_px[ci] & left_px & p;
			anch_one_up[ci-1] = a;
			if (a) begin
				if (anchors_found != COUNT_MAX)
					anchors_found = anchors_found + COUNT_W'(1);
				rec = '{KIND_ANCHOR, POS_OUT_W'(row_pos), POS_OUT_W'(col_pos), '0, 1'b0, 1'b0};
				pending_records.insert(pending_records.size(), rec);
			end
			// pixel up and left is now settled; so is the one above at row end
			if (above_px[ci-1] && !covered_by(anch_two_up, anch_one_up, ci - 1))
				uncovered = 1'b1;
			if (endc && above_px[ci] && !covered_by(anch_two_up, anch_one_up, ci))
				uncovered = 1'b1;
			if (row_pos == nr - 1) begin
				if (left_px && !covered_by('0, anch_one_up, ci - 1))
					uncovered = 1'b1;
				if (endc && p && !covered_by('0, anch_one_up, ci))
					uncovered = 1'b1;
			end
		end
		if (ci >= 1)
			above_px[ci-1] = left_px;
		if (endc)
			above_px[ci] = p;
		left_px = p;
		if (endc) begin
			col_pos = 0;
			if (row_pos == nr - 1) begin
				rec = '{KIND_VERDICT, '0, '0, anchors_found, !uncovered, 1'b1};
				pending_records.insert(pending_records.size(), rec);
				restart_frame();
			end else begin
				row_pos = row_pos + 1;
			end
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			pixel <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (pixel_valid && !pixel_stall) begin
				predict_pixel(pixel);
				pixels_taken++;
			end
			if (!pixel_valid || !pixel_stall) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					pixel_valid <= 1'b0;
				end else if (pixel_backlog.size() != 0) begin
					pixel_valid <= 1'b1;
					pixel <= pixel_backlog.pop_front();
					tx_gap <= tx_burst ? 0 : $urandom_range(0, 8);
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// record monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			rx_hold <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pending_records.size() == 0) begin
					$display({"%0t: record with nothing expected: expected none, ",
						"actual kind %0d row %0d col %0d count %0d"},
						$time, record_kind, anchor_row, anchor_col, anchor_count);
					mismatches++;
				end else begin
					want = pending_records.pop_front();
					check_field("record_kind", 16'(want.kind), 16'(record_kind));
					check_field("anchor_row", 16'(want.row), 16'(anchor_row));
					check_field("anchor_col", 16'(want.col), 16'(anchor_col));
					check_field("anchor_count", 16'(want.count), 16'(anchor_count));
					check_field("image_ok", 16'(want.ok), 16'(image_ok));
					check_field("last", 16'(want.last), 16'(last));
					if (want.kind == KIND_VERDICT) begin
						verdicts_seen++;
						clean_seen += int'(want.ok);
					end else begin
						anchors_checked++;
					end
				end
				rx_draw = rx_burst ? 0 : $urandom_range(0, 8);
				rx_hold <= rx_draw;
				result_stall <= (rx_draw != 0);
			end else if (rx_hold > 1) begin
				rx_hold <= rx_hold - 1;
			end else begin
				rx_hold <= 0;
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic drain();
		while (pixel_backlog.size() != 0 || pixel_valid || pending_records.size() != 0)
			@(posedge clk);
		// a pixel with no record may still be in the pipe
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_register(idx, val);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	task automatic push_pattern(input int n, input logic [15:0] bits);
		for (int i = n - 1; i >= 0; i--)
			pixel_backlog.insert(pixel_backlog.size(), bits[i]);
		pixels_queued += n;
	endtask

	task automatic push_range(input int nc, input int from, input int upto);
		for (int k = from; k < upto; k++)
			pixel_backlog.insert(pixel_backlog.size(), img[k/nc][k%nc]);
		pixels_queued += upto - from;
	endtask

	task automatic fill_frame(input int nr, input int nc, input frame_style_t st);
		int n, r, c, thr;
		for (r = 0; r < nr; r++)
			for (c = 0; c < nc; c++)
				img[r][c] = (st == STYLE_SOLID);
		thr = $urandom_range(1, 9);
		case (st)
			STYLE_SQUARES, STYLE_FLAWED: begin
				n = $urandom_range(1, nr * nc / 3 + 1);
				repeat (n) begin
					r = $urandom_range(0, nr - 2);
					c = $urandom_range(0, nc - 2);
					img[r][c] = 1'b1;
					img[r][c+1] = 1'b1;
					img[r+1][c] = 1'b1;
					img[r+1][c+1] = 1'b1;
				end
				if (st == STYLE_FLAWED) begin
					r = $urandom_range(0, nr - 1);
					c = $urandom_range(0, nc - 1);
					img[r][c] = !img[r][c];
				end
			end
			STYLE_NOISE:
				for (r = 0; r < nr; r++)
					for (c = 0; c < nc; c++)
						img[r][c] = ($urandom_range(0, 9) < thr);
			default: ;
		endcase
	endtask

	initial begin
		int               nr, nc, nframes, total, split, directed;
		logic [CFG_W-1:0] rv, cv, ext;
		frame_style_t     st;
		rows_reg = CFG_W'(2);
		cols_reg = CFG_W'(2);
		above_px = '0;
		anch_two_up = '0;
		anch_one_up = '0;
		left_px = 1'b0;
		restart_frame();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2x2 at reset size: full square gives anchor and verdict on one pixel
		push_pattern(4, 16'b1111);
		push_pattern(4, 16'b1000);
		drain();
		write_reg(REG_SPARE_3, 7'h7F);
		write_reg(REG_IMAGE_ROWS, 7'd0);
		write_reg(REG_IMAGE_COLS, 7'd3);
		push_pattern(6, 16'b011011);
		// unknown index mid-frame must not restart
		push_pattern(3, 16'b110);
		drain();
		write_reg(REG_SPARE_2, 7'h00);
		push_pattern(3, 16'b110);
		// size write mid-frame restarts
		push_pattern(2, 16'b11);
		drain();
		write_reg(REG_IMAGE_COLS, 7'd1);
		push_pattern(4, 16'b0111);
		drain();
		directed = pixels_queued;

		while (pixels_queued < directed + RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 4))
					0: ext = 7'd0;
					1: ext = 7'd1;
					2: ext = 7'd64;
					3: ext = 7'd65;
					default: ext = 7'd127;
				endcase
				if ($urandom_range(0, 1)) begin
					rv = ext;
					cv = CFG_W'($urandom_range(2, 3));
				end else begin
					rv = CFG_W'($urandom_range(2, 3));
					cv = ext;
				end
			end else begin
				rv = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(2, 16)) :
					CFG_W'($urandom_range(2, 6));
				cv = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(2, 16)) :
					CFG_W'($urandom_range(2, 6));
			end
			if ($urandom_range(0, 5) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
					CFG_W'($urandom_range(0, 127)));
			if ($urandom_range(0, 1)) begin
				write_reg(REG_IMAGE_ROWS, rv);
				write_reg(REG_IMAGE_COLS, cv);
			end else begin
				write_reg(REG_IMAGE_COLS, cv);
				write_reg(REG_IMAGE_ROWS, rv);
			end
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			nr = eff_size(rows_reg, NR);
			nc = eff_size(cols_reg, NC);
			total = nr * nc;
			nframes = $urandom_range(1, 3);
			for (int f = 0; f < nframes; f++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: st = STYLE_SQUARES;
					6, 7: st = STYLE_FLAWED;
					8: st = STYLE_NOISE;
					default: st = $urandom_range(0, 1) ? STYLE_SOLID : STYLE_BLANK;
				endcase
				fill_frame(nr, nc, st);
				split = $urandom_range(1, total - 1);
				case ($urandom_range(0, 9))
					0: begin
						// broken frame: the next size write restarts it
						push_range(nc, 0, split);
						break;
					end
					1: begin
						// hold the sender off until every record is in
						push_range(nc, 0, split);
						drain();
						push_range(nc, split, total);
					end
					default: push_range(nc, 0, total);
				endcase
			end
			drain();
		end

		$display("Covered %0d pixel transactions in %0d frames (%0d clean, %0d with strays)",
			pixels_taken, verdicts_seen, clean_seen, verdicts_seen - clean_seen);
		$display("Checked %0d anchor records over %0d register writes, sizes 2 to 64 each way",
			anchors_checked, cfg_writes);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sqc_pkg.sv
rtl/core/sqc_ram.sv
rtl/core/sqc_eval.sv
rtl/core/sqc_out.sv
rtl/core/square_cover_check_core.sv
tb/square_cover_check_core_tb.sv
